>>> rtl/core/kmpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keyed max priority queue.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package kmpq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned KEY_W  = 8;
  localparam int unsigned REL_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Command codes carried by the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_QUERY  = 3'd3,
    KIND_EXPIRE = 3'd4
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_DROP,
    ST_PACK,
    ST_DONE
  } state_e;

  // Operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_PUSH,
    CELL_EXPIRE,
    CELL_DROP,
    CELL_PACK
  } cell_op_e;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [REL_W-1:0]  rel;
    logic [TIME_W-1:0] created;
  } entry_t;

  // Running result handed from cell to cell during a scan
  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [REL_W-1:0] rel;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] rank;
  } carry_t;

  typedef struct packed {
    cell_op_e          op;
    logic [KEY_W-1:0]  key;
    logic [REL_W-1:0]  rel;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] expire_time;
    logic              hit;
    logic              full;
    logic [REL_W-1:0]  match_rel;
    logic [IDX_W-1:0]  drop_idx;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/keyed_max_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the keyed max priority queue: command sequencer, result
// register and configuration register. Depends on kmpq_pkg and kmpq_chain.
//
//   Commands enter on the in channel (kind, key, relevance, now_time) with
//   valid/ready; each command returns exactly one item on the out channel.
//   expire_time is written on the cfg channel, which is always ready; write
//   it only while no command is in flight.
//   The result register loads once the command has passed these states:
//     push, unused kind codes  LOOK, then DONE
//     peek, query, pop         LOOK, SCAN (one pass of the scan carry through
//                              the cell row), DONE; a pop that finds an entry
//                              runs DROP, then PACK until no hole is left
//     expire sweep             LOOK, then PACK until no hole is left below a
//                              valid entry, then DONE
//   One command is worked on at a time; in_ready_o is high only while the
//   sequencer is idle, from the cycle after the result register loads. A
//   finished result waits in the output register and the next command may be
//   accepted meanwhile; it completes only once the register is free, so a
//   stalled receiver holds the block.
//   Reset empties the table and clears expire_time, which disables expiry.
`default_nettype none

module keyed_max_priority_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmpq_pkg::KIND_W-1:0]   kind_i,
  input  logic [kmpq_pkg::KEY_W-1:0]    key_i,
  input  logic [kmpq_pkg::REL_W-1:0]    relevance_i,
  input  logic [kmpq_pkg::TIME_W-1:0]   now_time_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [kmpq_pkg::KEY_W-1:0]    out_key_o,
  output logic [kmpq_pkg::REL_W-1:0]    out_relevance_o,
  output logic [kmpq_pkg::CNT_W-1:0]    out_rank_o,
  output logic [kmpq_pkg::CNT_W-1:0]    out_count_o,
  output logic                          dropped_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kmpq_pkg::TIME_W-1:0]   cfg_data_i
);
  import kmpq_pkg::*;

  state_e            state_q, state_d;
  logic [KIND_W-1:0] kind_q;
  logic [KEY_W-1:0]  key_q;
  logic [REL_W-1:0]  rel_q;
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] expire_time_q;
  logic [CNT_W-1:0]  scan_cnt_q, scan_cnt_d;
  logic              hit_q;
  logic [KEY_W-1:0]  match_key_q;
  logic [REL_W-1:0]  match_rel_q;
  logic              dropped_q;
  carry_t            best_q;

  logic              out_valid_q;
  logic              found_q;
  logic [KEY_W-1:0]  out_key_q;
  logic [REL_W-1:0]  out_rel_q;
  logic [CNT_W-1:0]  out_rank_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_dropped_q;

  cell_ctl_t         ctl;
  logic [DEPTH-1:0]  valid;
  logic              hit;
  logic [KEY_W-1:0]  hit_key;
  logic [REL_W-1:0]  hit_rel;
  carry_t            last_carry;
  logic              packed_row;
  logic [CNT_W-1:0]  count;
  logic              full;
  logic              scan_end;
  logic              out_free;
  logic              in_fire;

  kmpq_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .valid_o   (valid),
    .hit_o     (hit),
    .hit_key_o (hit_key),
    .hit_rel_o (hit_rel),
    .carry_o   (last_carry)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign full        = valid[DEPTH-1];
  assign scan_end    = (scan_cnt_q == CNT_W'(DEPTH));
  assign out_free    = !out_valid_q || out_ready_i;

  // Detect a hole below a valid entry; count entries
  always_comb begin
    packed_row = 1'b1;
    count      = '0;
    for (int i = 0; i < DEPTH; i++) begin
      count = count + CNT_W'(valid[i]);
      if (i < DEPTH - 1) begin
        if (!valid[i] && valid[i+1]) begin
          packed_row = 1'b0;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        case (kind_q)
          KIND_POP, KIND_PEEK, KIND_QUERY: state_d = ST_SCAN;
          KIND_EXPIRE:                     state_d = ST_PACK;
          default:                         state_d = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ((kind_q == KIND_POP) && last_carry.found) ? ST_DROP : ST_DONE;
        end
      end
      ST_DROP: begin
        state_d = ST_PACK;
      end
      ST_PACK: begin
        if (packed_row) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Cell commands
  always_comb begin
    ctl.op          = CELL_IDLE;
    ctl.key         = key_q;
    ctl.rel         = rel_q;
    ctl.now         = now_q;
    ctl.expire_time = expire_time_q;
    ctl.hit         = hit;
    ctl.full        = full;
    ctl.match_rel   = match_rel_q;
    ctl.drop_idx    = best_q.idx;
    unique case (state_q)
      ST_LOOK: begin
        if (kind_q == KIND_PUSH) begin
          ctl.op = CELL_PUSH;
        end else if ((kind_q == KIND_EXPIRE) && (expire_time_q != '0)) begin
          ctl.op = CELL_EXPIRE;
        end
      end
      ST_DROP: ctl.op = CELL_DROP;
      ST_PACK: begin
        if (!packed_row) begin
          ctl.op = CELL_PACK;
        end
      end
      default: ctl.op = CELL_IDLE;
    endcase
  end

  // Scan counter
  always_comb begin
    scan_cnt_d = scan_cnt_q;
    if (state_q == ST_LOOK) begin
      scan_cnt_d = '0;
    end else if ((state_q == ST_SCAN) && !scan_end) begin
      scan_cnt_d = scan_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_cnt_q    <= '0;
      expire_time_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      if (cfg_valid_i) begin
        expire_time_q <= cfg_data_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the command and intermediate results
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_i;
      key_q  <= key_i;
      rel_q  <= relevance_i;
      now_q  <= now_time_i;
    end
    if (state_q == ST_LOOK) begin
      hit_q       <= hit;
      match_key_q <= hit_key;
      match_rel_q <= hit_rel;
      dropped_q   <= (kind_q == KIND_PUSH) && !hit && full;
    end
    if ((state_q == ST_SCAN) && scan_end) begin
      best_q <= last_carry;
    end
  end

  // Load the result register
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      found_q       <= 1'b0;
      out_key_q     <= '0;
      out_rel_q     <= '0;
      out_rank_q    <= '0;
      out_dropped_q <= 1'b0;
      out_count_q   <= count;
      case (kind_q)
        KIND_PUSH: begin
          out_dropped_q <= dropped_q;
        end
        KIND_POP, KIND_PEEK: begin
          found_q <= best_q.found;
          if (best_q.found) begin
            out_key_q <= best_q.key;
            out_rel_q <= best_q.rel;
          end
        end
        KIND_QUERY: begin
          found_q <= hit_q;
          if (hit_q) begin
            out_key_q  <= match_key_q;
            out_rel_q  <= match_rel_q;
            out_rank_q <= best_q.rank + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign out_key_o       = out_key_q;
  assign out_relevance_o = out_rel_q;
  assign out_rank_o      = out_rank_q;
  assign out_count_o     = out_count_q;
  assign dropped_o       = out_dropped_q;

endmodule

`default_nettype wire

>>> rtl/core/kmpq_cell.sv
`timescale 1ns / 1ps
// One slot of the queue: holds an entry, updates it on broadcast commands,
// shifts from its upper neighbor on compaction and forwards the scan carry.
// Depends on kmpq_pkg.
`default_nettype none

module kmpq_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [kmpq_pkg::IDX_W-1:0] idx_i,
  input  kmpq_pkg::cell_ctl_t      ctl_i,
  input  kmpq_pkg::entry_t         upper_i,
  input  logic                     lower_valid_i,
  input  logic                     hole_i,
  input  kmpq_pkg::carry_t         carry_i,
  output kmpq_pkg::entry_t         entry_o,
  output logic                     hole_o,
  output logic                     match_o,
  output kmpq_pkg::carry_t         carry_o
);
  import kmpq_pkg::*;

  logic              valid_q, valid_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [REL_W-1:0]  rel_q, rel_d;
  logic [TIME_W-1:0] created_q, created_d;
  carry_t            carry_q, carry_d;
  logic              match;
  logic              first_free;
  logic              expired;
  logic              shift;
  logic [TIME_W-1:0] age;
  logic              take;
  logic              ahead;

  // Compare against the broadcast command
  assign match      = valid_q && (key_q == ctl_i.key);
  assign first_free = !valid_q && lower_valid_i;
  assign age        = ctl_i.now - created_q;
  assign expired    = valid_q && (age >= ctl_i.expire_time);
  assign shift      = hole_i || !valid_q;

  assign hole_o  = shift;
  assign match_o = match;
  assign entry_o = '{valid: valid_q, key: key_q, rel: rel_q, created: created_q};

  // Update the slot
  always_comb begin
    valid_d   = valid_q;
    key_d     = key_q;
    rel_d     = rel_q;
    created_d = created_q;
    unique case (ctl_i.op)
      CELL_PUSH: begin
        if (match) begin
          if (ctl_i.rel > rel_q) begin
            rel_d = ctl_i.rel;
          end
        end else if (!ctl_i.hit && !ctl_i.full && first_free) begin
          valid_d   = 1'b1;
          key_d     = ctl_i.key;
          rel_d     = ctl_i.rel;
          created_d = ctl_i.now;
        end
      end
      CELL_EXPIRE: begin
        if (expired) begin
          valid_d = 1'b0;
        end
      end
      CELL_DROP: begin
        if (idx_i == ctl_i.drop_idx) begin
          valid_d = 1'b0;
        end
      end
      CELL_PACK: begin
        if (shift) begin
          valid_d   = upper_i.valid;
          key_d     = upper_i.key;
          rel_d     = upper_i.rel;
          created_d = upper_i.created;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the scan carry: keep the earliest best, count entries ahead
  always_comb begin
    take  = valid_q && (!carry_i.found || (rel_q > carry_i.rel));
    ahead = valid_q && (rel_q > ctl_i.match_rel);
    carry_d       = carry_i;
    carry_d.found = carry_i.found | valid_q;
    carry_d.rank  = carry_i.rank + CNT_W'(ahead);
    if (take) begin
      carry_d.key = key_q;
      carry_d.rel = rel_q;
      carry_d.idx = idx_i;
    end
  end

  assign carry_o = carry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    rel_q     <= rel_d;
    created_q <= created_d;
    carry_q   <= carry_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/kmpq_chain.sv
`timescale 1ns / 1ps
// Row of queue cells, oldest entry in cell zero, with neighbor wiring and
// the key-match reduction. Depends on kmpq_pkg and kmpq_cell.
`default_nettype none

module kmpq_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmpq_pkg::cell_ctl_t           ctl_i,
  output logic [kmpq_pkg::DEPTH-1:0]    valid_o,
  output logic                          hit_o,
  output logic [kmpq_pkg::KEY_W-1:0]    hit_key_o,
  output logic [kmpq_pkg::REL_W-1:0]    hit_rel_o,
  output kmpq_pkg::carry_t              carry_o
);
  import kmpq_pkg::*;

  entry_t             entry [DEPTH];
  entry_t             upper [DEPTH];
  carry_t             carry_out [DEPTH];
  carry_t             carry_in [DEPTH];
  logic [DEPTH-1:0]   hole;
  logic [DEPTH-1:0]   hole_in;
  logic [DEPTH-1:0]   lower_valid;
  logic [DEPTH-1:0]   match;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign carry_in[i]    = '0;
      assign hole_in[i]     = 1'b0;
      assign lower_valid[i] = 1'b1;
    end else begin : g_rest
      assign carry_in[i]    = carry_out[i-1];
      assign hole_in[i]     = hole[i-1];
      assign lower_valid[i] = entry[i-1].valid;
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper[i] = '0;
    end else begin : g_inner
      assign upper[i] = entry[i+1];
    end

    kmpq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .idx_i         (IDX_W'(i)),
      .ctl_i         (ctl_i),
      .upper_i       (upper[i]),
      .lower_valid_i (lower_valid[i]),
      .hole_i        (hole_in[i]),
      .carry_i       (carry_in[i]),
      .entry_o       (entry[i]),
      .hole_o        (hole[i]),
      .match_o       (match[i]),
      .carry_o       (carry_out[i])
    );

    assign valid_o[i] = entry[i].valid;
  end

  assign carry_o = carry_out[DEPTH-1];
  assign hit_o   = |match;

  // Select the matching entry; keys are unique so at most one is set
  always_comb begin
    hit_key_o = '0;
    hit_rel_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_key_o = hit_key_o | (entry[i].key & {KEY_W{match[i]}});
      hit_rel_o = hit_rel_o | (entry[i].rel & {REL_W{match[i]}});
    end
  end

endmodule

`default_nettype wire
